// ----- design/com_pkg.sv -----
// Shared types, constants and helper functions for center_of_mass_correction.
// No dependencies; imported by com_ctrl, com_dp and the top level.
`timescale 1ns / 1ps
package com_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int IDX_W         = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int DATA_W        = 32;
    localparam int MASS_W        = 31;
    localparam int ITEM_W        = 6 * DATA_W + MASS_W;
    localparam int TDATA_W       = ((ITEM_W + 7) / 8) * 8;
    localparam int OUT_W         = 7 * DATA_W;
    localparam int OUT_TDATA_W   = ((OUT_W + 7) / 8) * 8;

    // shared divider geometry
    localparam int DVD_W     = 69;
    localparam int DSR_W     = 37;
    localparam int REM_W     = DSR_W + 1;
    localparam int QUO_W     = 34;
    localparam int DIV_CNT_W = 7;
    localparam int NUM_DIV   = 6;
    localparam int SEL_W     = 3;

    // square root geometry
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SQREM_W    = 34;
    localparam int SQ_CNT_W   = 6;

    // last field in the lowest bits
    typedef struct packed {
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_x;
        logic        [MASS_W-1:0] mass;
        logic signed [DATA_W-1:0] mom_z;
        logic signed [DATA_W-1:0] mom_y;
        logic signed [DATA_W-1:0] mom_x;
    } item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SUM,
        S_DIVGO,
        S_DIV,
        S_RD,
        S_SHIFT,
        S_SQ,
        S_ESUM,
        S_SQRT,
        S_WAITO
    } state_t;

    typedef struct packed {
        logic take;
        logic wr;
        logic div_start;
        logic rd;
        logic shift;
        logic sq;
        logic esum;
        logic out_load;
        logic emit_next;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic div_done;
        logic sqrt_done;
        logic out_free;
        logic emit_last;
        logic empty;
    } sts_t;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
        begin
            return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ----- design/com_ctrl.sv -----
// Sequencer for center_of_mass_correction: load, divide, emit phases.
// Depends on com_pkg; drives com_dp through cmd_t and reads sts_t.
`timescale 1ns / 1ps
module com_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  com_pkg::sts_t sts,
    output com_pkg::cmd_t cmd
);
    import com_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_LOAD;
            S_LOAD:  state_next = sts.last ? S_SUM : S_IDLE;
            S_SUM:   state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIV;
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = sts.empty ? S_IDLE : S_RD;
            end
            S_RD:    state_next = S_SHIFT;
            S_SHIFT: state_next = S_SQ;
            S_SQ:    state_next = S_ESUM;
            S_ESUM:  state_next = S_SQRT;
            S_SQRT:  if (sts.sqrt_done) state_next = S_WAITO;
            S_WAITO:
            begin
                if (sts.out_free)
                    state_next = sts.emit_last ? S_IDLE : S_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:  cmd.take = 1'b1;
            S_LOAD:  cmd.wr = 1'b1;
            S_DIVGO: cmd.div_start = 1'b1;
            S_DIV:   cmd.clear = sts.div_done && sts.empty;
            S_RD:    cmd.rd = 1'b1;
            S_SHIFT: cmd.shift = 1'b1;
            S_SQ:    cmd.sq = 1'b1;
            S_ESUM:  cmd.esum = 1'b1;
            S_WAITO:
            begin
                cmd.out_load  = sts.out_free;
                cmd.clear     = sts.out_free && sts.emit_last;
                cmd.emit_next = sts.out_free && !sts.emit_last;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ----- design/com_dp.sv -----
// Datapath: particle store, running sums, shared divider, square root, output register.
// Depends on com_pkg; commanded by com_ctrl.
`timescale 1ns / 1ps
module com_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  com_pkg::cmd_t                     cmd,
    output com_pkg::sts_t                     sts,
    input  logic                              in_valid,
    input  logic [com_pkg::ITEM_W-1:0]        in_item,
    input  logic                              in_last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [com_pkg::OUT_TDATA_W-1:0]   out_data,
    output logic                              out_last,
    output logic                              out_overflow
);
    import com_pkg::*;

    // input capture
    item_t item_reg;
    logic  last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take && in_valid)
        begin
            item_reg <= item_t'(in_item);
            last_reg <= in_last;
        end
    end

    // store
    logic [ITEM_W-1:0] mem [MAX_PARTICLES];
    item_t             mem_q;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  emit_idx_reg;
    logic              full;

    assign full = (cnt_reg == CNT_W'(MAX_PARTICLES));

    always_ff @(posedge clk)
    begin
        if (cmd.wr && !full)
            mem[cnt_reg[IDX_W-1:0]] <= item_reg;
        if (cmd.rd)
            mem_q <= item_t'(mem[emit_idx_reg[IDX_W-1:0]]);
    end

    // weighted products, added to the sums in the following cycle
    logic        [62:0]       prod_reg [3];
    logic                     acc_neg_reg [3];
    logic signed [DATA_W-1:0] acc_mom_reg [3];
    logic        [MASS_W-1:0] acc_mass_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            prod_reg[0]    <= 63'(mag32(item_reg.pos_x)) * 63'(item_reg.mass);
            prod_reg[1]    <= 63'(mag32(item_reg.pos_y)) * 63'(item_reg.mass);
            prod_reg[2]    <= 63'(mag32(item_reg.pos_z)) * 63'(item_reg.mass);
            acc_neg_reg[0] <= item_reg.pos_x[DATA_W-1];
            acc_neg_reg[1] <= item_reg.pos_y[DATA_W-1];
            acc_neg_reg[2] <= item_reg.pos_z[DATA_W-1];
            acc_mom_reg[0] <= item_reg.mom_x;
            acc_mom_reg[1] <= item_reg.mom_y;
            acc_mom_reg[2] <= item_reg.mom_z;
            acc_mass_reg   <= item_reg.mass;
        end
    end

    logic               acc_vld_reg;
    logic               dropped_reg;
    logic signed [37:0] sum_mom_reg [3];
    logic signed [63:0] sum_wp_reg [3];
    logic        [36:0] sum_mass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            dropped_reg  <= 1'b0;
            acc_vld_reg  <= 1'b0;
            sum_mass_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_mom_reg[i] <= '0;
                sum_wp_reg[i]  <= '0;
            end
        end
        else if (cmd.clear)
        begin
            cnt_reg      <= '0;
            dropped_reg  <= 1'b0;
            acc_vld_reg  <= 1'b0;
            sum_mass_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_mom_reg[i] <= '0;
                sum_wp_reg[i]  <= '0;
            end
        end
        else
        begin
            acc_vld_reg <= cmd.wr && !full;
            if (cmd.wr)
            begin
                if (full)
                    dropped_reg <= 1'b1;
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
            if (acc_vld_reg)
            begin
                sum_mass_reg <= sum_mass_reg + 37'(acc_mass_reg);
                for (int i = 0; i < 3; i++)
                begin
                    sum_mom_reg[i] <= sum_mom_reg[i] + 38'(acc_mom_reg[i]);
                    if (acc_neg_reg[i])
                        sum_wp_reg[i] <= sum_wp_reg[i] - $signed({17'b0, prod_reg[i][62:16]});
                    else
                        sum_wp_reg[i] <= sum_wp_reg[i] + $signed({17'b0, prod_reg[i][62:16]});
                end
            end
        end
    end

    // shared restoring divider, runs the six shifts back to back
    logic                     div_busy_reg;
    logic                     div_fin_reg;
    logic [SEL_W-1:0]         div_sel_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic [DVD_W-1:0]         div_dvd_reg;
    logic [DSR_W-1:0]         div_dsr_reg;
    logic [REM_W-1:0]         div_rem_reg;
    logic [QUO_W-1:0]         div_quo_reg;
    logic                     div_ovf_reg;
    logic                     div_neg_reg;
    logic                     div_zero_reg;
    logic signed [DATA_W-1:0] sh_reg [NUM_DIV];

    logic [SEL_W-1:0]  ld_sel;
    logic [DVD_W-1:0]  ld_dvd;
    logic [DSR_W-1:0]  ld_dsr;
    logic              ld_neg;
    logic              ld_zero;
    logic [63:0]       wp_mag;
    logic [37:0]       mom_mag;
    logic [1:0]        ld_j;

    always_comb
    begin
        ld_sel  = cmd.div_start ? '0 : div_sel_reg + 1'b1;
        ld_j    = 2'd0;
        wp_mag  = '0;
        mom_mag = '0;
        if (ld_sel < SEL_W'(3))
        begin
            ld_j    = ld_sel[1:0];
            ld_neg  = sum_wp_reg[ld_j][63];
            wp_mag  = ld_neg ? 64'(-sum_wp_reg[ld_j]) : 64'(sum_wp_reg[ld_j]);
            ld_dvd  = {wp_mag[52:0], 16'b0};
            ld_dsr  = sum_mass_reg;
            ld_zero = (sum_mass_reg == '0);
        end
        else
        begin
            ld_j    = 2'(ld_sel - SEL_W'(3));
            ld_neg  = sum_mom_reg[ld_j][37];
            mom_mag = ld_neg ? 38'(-sum_mom_reg[ld_j]) : 38'(sum_mom_reg[ld_j]);
            ld_dvd  = DVD_W'(mom_mag);
            ld_dsr  = DSR_W'(cnt_reg);
            ld_zero = 1'b0;
        end
    end

    logic [REM_W:0]           div_r2;
    logic                     div_ge;
    logic [REM_W-1:0]         div_rem_n;
    logic [QUO_W-1:0]         div_quo_n;
    logic                     div_ovf_n;
    logic [32:0]              div_qc;
    logic signed [DATA_W-1:0] div_val;

    always_comb
    begin
        div_r2    = {div_rem_reg, div_dvd_reg[DVD_W-1]};
        div_ge    = (div_r2 >= (REM_W+1)'(div_dsr_reg));
        div_rem_n = div_ge ? REM_W'(div_r2 - (REM_W+1)'(div_dsr_reg)) : div_r2[REM_W-1:0];
        div_quo_n = {div_quo_reg[QUO_W-2:0], div_ge};
        div_ovf_n = div_ovf_reg | div_quo_reg[QUO_W-1];
        // clamp the quotient at 2^32, then to signed 32 bit with the sign flipped
        if (div_ovf_n || (div_quo_n > 34'h1_0000_0000))
            div_qc = 33'h1_0000_0000;
        else
            div_qc = div_quo_n[32:0];
        if (div_zero_reg)
            div_val = '0;
        else if (div_neg_reg)
            div_val = (div_qc >= 33'h0_8000_0000) ? 32'sh7FFF_FFFF : $signed(div_qc[31:0]);
        else
            div_val = (div_qc > 33'h0_8000_0000) ? 32'sh8000_0000 : $signed(-div_qc[31:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_fin_reg  <= 1'b0;
            div_sel_reg  <= '0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_fin_reg  <= 1'b0;
            div_sel_reg  <= ld_sel;
            div_cnt_reg  <= DIV_CNT_W'(DVD_W);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (div_cnt_reg == DIV_CNT_W'(1))
            begin
                if (div_sel_reg == SEL_W'(NUM_DIV - 1))
                begin
                    div_busy_reg <= 1'b0;
                    div_fin_reg  <= 1'b1;
                end
                else
                begin
                    div_sel_reg <= ld_sel;
                    div_cnt_reg <= DIV_CNT_W'(DVD_W);
                end
            end
        end
        else if (cmd.rd)
        begin
            div_fin_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start || (div_busy_reg && div_cnt_reg == DIV_CNT_W'(1)))
        begin
            div_dvd_reg  <= ld_dvd;
            div_dsr_reg  <= ld_dsr;
            div_neg_reg  <= ld_neg;
            div_zero_reg <= ld_zero;
            div_rem_reg  <= '0;
            div_quo_reg  <= '0;
            div_ovf_reg  <= 1'b0;
        end
        else if (div_busy_reg)
        begin
            div_dvd_reg <= {div_dvd_reg[DVD_W-2:0], 1'b0};
            div_rem_reg <= div_rem_n;
            div_quo_reg <= div_quo_n;
            div_ovf_reg <= div_ovf_n;
        end
        if (div_busy_reg && div_cnt_reg == DIV_CNT_W'(1))
            sh_reg[div_sel_reg] <= div_val;
    end

    // emit pipeline: shift, square, sum
    logic signed [DATA_W-1:0] pos_o_reg [3];
    logic signed [DATA_W-1:0] mom_o_reg [3];
    logic        [MASS_W-1:0] mass_o_reg;
    logic        [62:0]       sq_reg [4];

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            pos_o_reg[0] <= sat_add(mem_q.pos_x, sh_reg[0]);
            pos_o_reg[1] <= sat_add(mem_q.pos_y, sh_reg[1]);
            pos_o_reg[2] <= sat_add(mem_q.pos_z, sh_reg[2]);
            mom_o_reg[0] <= sat_add(mem_q.mom_x, sh_reg[3]);
            mom_o_reg[1] <= sat_add(mem_q.mom_y, sh_reg[4]);
            mom_o_reg[2] <= sat_add(mem_q.mom_z, sh_reg[5]);
            mass_o_reg   <= mem_q.mass;
        end
        if (cmd.sq)
        begin
            sq_reg[0] <= 63'(mass_o_reg) * 63'(mass_o_reg);
            for (int i = 0; i < 3; i++)
                sq_reg[i+1] <= 63'(mag32(mom_o_reg[i])) * 63'(mag32(mom_o_reg[i]));
        end
    end

    // bit-pair square root; the sum of four squares stays below 2^64
    logic                sq_busy_reg;
    logic [SQ_CNT_W-1:0] sq_cnt_reg;
    logic [RAD_W-1:0]    sq_rad_reg;
    logic [SQREM_W-1:0]  sq_rem_reg;
    logic [ROOT_W-1:0]   sq_root_reg;
    logic [SQREM_W+1:0]  sq_r2;
    logic [SQREM_W+1:0]  sq_trial;
    logic                sq_ge;

    always_comb
    begin
        sq_r2    = {sq_rem_reg, sq_rad_reg[RAD_W-1:RAD_W-2]};
        sq_trial = (SQREM_W+2)'({sq_root_reg, 2'b01});
        sq_ge    = (sq_r2 >= sq_trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end
        else if (cmd.esum)
        begin
            sq_busy_reg <= 1'b1;
            sq_cnt_reg  <= SQ_CNT_W'(ROOT_W);
        end
        else if (sq_busy_reg)
        begin
            sq_cnt_reg <= sq_cnt_reg - 1'b1;
            if (sq_cnt_reg == SQ_CNT_W'(1))
                sq_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.esum)
        begin
            sq_rad_reg  <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]) + 64'(sq_reg[3]);
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (sq_busy_reg)
        begin
            sq_rad_reg  <= {sq_rad_reg[RAD_W-3:0], 2'b00};
            sq_rem_reg  <= sq_ge ? SQREM_W'(sq_r2 - sq_trial) : sq_r2[SQREM_W-1:0];
            sq_root_reg <= {sq_root_reg[ROOT_W-2:0], sq_ge};
        end
    end

    // output register and emit index
    logic                   out_vld_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;
    logic                   out_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            emit_idx_reg <= '0;
        end
        else
        begin
            if (cmd.out_load)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
            if (cmd.clear)
                emit_idx_reg <= '0;
            else if (cmd.emit_next)
                emit_idx_reg <= emit_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= OUT_TDATA_W'({sq_root_reg, mom_o_reg[2], mom_o_reg[1], mom_o_reg[0],
                                          pos_o_reg[2], pos_o_reg[1], pos_o_reg[0]});
            out_last_reg <= sts.emit_last;
            out_ovf_reg  <= dropped_reg;
        end
    end

    assign out_valid    = out_vld_reg;
    assign out_data     = out_data_reg;
    assign out_last     = out_last_reg;
    assign out_overflow = out_ovf_reg;

    always_comb
    begin
        sts.last      = last_reg;
        sts.div_done  = div_fin_reg;
        sts.sqrt_done = !sq_busy_reg;
        sts.out_free  = !out_vld_reg || out_ready;
        sts.emit_last = (CNT_W'(emit_idx_reg + 1'b1) == cnt_reg);
        sts.empty     = (cnt_reg == '0);
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_PARTICLES))
        else $error("particle count beyond capacity");

    a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_busy_reg && sq_busy_reg))
        else $error("divider and square root busy together");

    a_acc_follows_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr && !full |=> acc_vld_reg)
        else $error("stored beat not summed");

    a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_vld_reg || out_ready))
        else $error("output register overwritten");

endmodule

// ----- design/center_of_mass_correction.sv -----
// Top level: loads up to MAX_PARTICLES beats; each beat is captured, then stored and multiplied, and
// the next beat is taken only after that. After the beat with tlast the sums settle, then the six
// shifts run back to back on one shared restoring divider; per particle come read, shift, square, sum,
// the square-root unit and the load of the output register, which waits while the sink stalls.
// Reset (rst_n low, asynchronous) empties the set and clears sums, count and drop flag.
// Depends on com_pkg, com_ctrl and com_dp.
`timescale 1ns / 1ps
module center_of_mass_correction (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side: particles
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, low bit up: in_mom_x, in_mom_y, in_mom_z, in_mass(31), in_pos_x, in_pos_y,
    // in_pos_z, one zero pad bit
    input  logic [com_pkg::TDATA_W-1:0]       s_axis_tdata,
    input  logic                              s_axis_tlast,     // in_last
    // master side: corrected particles
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, low bit up: out_pos_x, out_pos_y, out_pos_z, out_mom_x, out_mom_y, out_mom_z,
    // out_energy
    output logic [com_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,     // out_last
    output logic                              m_axis_tuser      // out_overflow
);
    import com_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // ready only while the sequencer waits for the next particle
    assign s_axis_tready = cmd.take;

    com_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath holds the store, sums, divider, root unit and the output beat register
    com_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_valid     (s_axis_tvalid),
        .in_item      (s_axis_tdata[ITEM_W-1:0]),
        .in_last      (s_axis_tlast),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_last     (m_axis_tlast),
        .out_overflow (m_axis_tuser)
    );

endmodule

// ----- tb/center_of_mass_correction_test.sv -----
// Testbench for center_of_mass_correction: streams particle sets, predicts corrected beats.
// Depends on com_pkg and the design top level; self-checking, no external files.
`timescale 1ns / 1ps
module center_of_mass_correction_test;
    import com_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  ITEM_GOAL   = 470;

    // one particle as it goes into the block, plus a hold-off mark for the driver
    typedef struct {
        logic signed [31:0] mom [3];
        logic        [30:0] mass;
        logic signed [31:0] pos [3];
        logic               last;
        logic               hold;
    } particle_t;

    // one corrected beat: pos x,y,z, mom x,y,z, energy in that order
    typedef struct {
        logic [31:0] word [7];
        logic        last;
        logic        ovf;
    } corrected_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    center_of_mass_correction u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    particle_t  pending_q [$];
    corrected_t corrected_q [$];
    int         accepted;
    int         errors;
    int         cycles;

    // shadow of the block's set store and running sums
    logic signed [31:0] set_mom  [64][3];
    logic        [30:0] set_mass [64];
    logic signed [31:0] set_pos  [64][3];
    int                 set_count;
    longint             mom_sum  [3];
    longint             wpos_sum [3];
    longint unsigned    mass_sum;
    logic               dropped;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // mass-weighted position term, truncated magnitude carrying the sign of pos
    function automatic longint weight_term(input logic signed [31:0] p, input logic [30:0] m);
        longint unsigned prod;
        prod = (magnitude(longint'(p)) * longint'(m)) >> 16;
        return (p < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // minus S/M in Q.16, quotient clipped at 2^32 before negation and saturation
    function automatic logic signed [31:0] pos_shift(input longint s, input longint unsigned m);
        logic [127:0] num;
        logic [127:0] quo;
        if (m == 0)
        begin
            return '0;
        end
        num = 128'(magnitude(s) & 64'h001f_ffff_ffff_ffff) << 16;
        quo = num / 128'(m);
        if (quo > 128'h1_0000_0000)
        begin
            quo = 128'h1_0000_0000;
        end
        return clamp32((s < 0) ? longint'(quo) : -longint'(quo));
    endfunction

    function automatic logic [31:0] root64(input logic [63:0] v);
        logic [31:0]  r;
        logic [31:0]  t;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (32'd1 << b);
            if (64'(t) * 64'(t) <= v)
            begin
                r = t;
            end
        end
        return r;
    endfunction

    task automatic clear_set();
        set_count = 0;
        mass_sum  = 0;
        dropped   = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            mom_sum[k]  = 0;
            wpos_sum[k] = 0;
        end
    endtask

    // absorb one accepted particle; on the last one push every corrected beat
    task automatic predict_set(input particle_t it);
        logic signed [31:0] psh [3];
        logic signed [31:0] msh [3];
        logic signed [31:0] pm  [3];
        logic [65:0]        e2;
        corrected_t         c;
        if (set_count < MAX_PARTICLES)
        begin
            for (int k = 0; k < 3; k++)
            begin
                set_mom[set_count][k] = it.mom[k];
                set_pos[set_count][k] = it.pos[k];
                mom_sum[k]  += longint'(it.mom[k]);
                wpos_sum[k] += weight_term(it.pos[k], it.mass);
            end
            set_mass[set_count] = it.mass;
            mass_sum += longint'(it.mass);
            set_count++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (!it.last)
        begin
            return;
        end
        for (int k = 0; k < 3; k++)
        begin
            psh[k] = pos_shift(wpos_sum[k], mass_sum);
            msh[k] = clamp32(-(mom_sum[k] / longint'(set_count)));
        end
        for (int n = 0; n < set_count; n++)
        begin
            e2 = 66'(64'(set_mass[n]) * 64'(set_mass[n]));
            for (int k = 0; k < 3; k++)
            begin
                pm[k] = clamp32(longint'(set_mom[n][k]) + longint'(msh[k]));
                c.word[k]     = clamp32(longint'(set_pos[n][k]) + longint'(psh[k]));
                c.word[3 + k] = pm[k];
                e2 += 66'(magnitude(longint'(pm[k])) * magnitude(longint'(pm[k])));
            end
            // saturate the energy square at 2^64 - 1
            c.word[6] = (e2[65:64] != 0) ? 32'hffffffff : root64(e2[63:0]);
            c.last    = (n + 1 == set_count);
            c.ovf     = dropped;
            corrected_q.push_back(c);
        end
        clear_set();
    endtask

    function automatic logic [TDATA_W-1:0] pack_particle(input particle_t it);
        return {1'b0, it.pos[2], it.pos[1], it.pos[0], it.mass, it.mom[2], it.mom[1], it.mom[0]};
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3, 4: return 32'($urandom_range(0, 32'h000f_ffff)) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_mass();
        case ($urandom_range(0, 9))
            0: return 31'h7fffffff;
            1: return 31'h0;
            2, 3: return 31'($urandom_range(0, 32'h0004_0000));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic particle_t mk_particle(input logic [31:0] m0, input logic [31:0] m1,
                                              input logic [31:0] m2, input logic [30:0] ms,
                                              input logic [31:0] p0, input logic [31:0] p1,
                                              input logic [31:0] p2, input logic lst);
        particle_t it;
        it.mom[0] = m0;
        it.mom[1] = m1;
        it.mom[2] = m2;
        it.mass   = ms;
        it.pos[0] = p0;
        it.pos[1] = p1;
        it.pos[2] = p2;
        it.last   = lst;
        it.hold   = 1'b0;
        return it;
    endfunction

    // idle rates per phase: sender 25 / receiver 71, then swapped, then none
    function automatic int send_idle();
        if (accepted < ITEM_GOAL / 3)
        begin
            return 25;
        end
        return (accepted < 2 * ITEM_GOAL / 3) ? 71 : 0;
    endfunction

    function automatic int recv_idle();
        if (accepted < ITEM_GOAL / 3)
        begin
            return 71;
        end
        return (accepted < 2 * ITEM_GOAL / 3) ? 25 : 0;
    endfunction

    // driver: hold a beat until accepted, then advance to the next pending particle
    always @(posedge clk or negedge rst_n)
    begin
        logic      in_flight;
        particle_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            in_flight = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_set(pending_q.pop_front());
                accepted++;
                in_flight = 1'b0;
            end
            if (!in_flight)
            begin
                if (pending_q.size() > 0 && (!pending_q[0].hold || corrected_q.size() == 0)
                    && $urandom_range(0, 99) >= send_idle())
                begin
                    nxt = pending_q[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pack_particle(nxt);
                    s_axis_tlast  <= nxt.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: stall at random, compare each beat with the oldest corrected particle
    always @(posedge clk or negedge rst_n)
    begin
        corrected_t want;
        string      names [7];
        names = '{"pos_x", "pos_y", "pos_z", "mom_x", "mom_y", "mom_z", "energy"};
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle());
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (corrected_q.size() == 0)
                begin
                    $display("%0t: unexpected beat tdata=%h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = corrected_q.pop_front();
                    for (int k = 0; k < 7; k++)
                    begin
                        if (m_axis_tdata[32*k +: 32] !== want.word[k])
                        begin
                            $display("%0t: %s expected %h actual %h", $time, names[k],
                                     want.word[k], m_axis_tdata[32*k +: 32]);
                            errors++;
                        end
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: tlast expected %b actual %b", $time, want.last,
                                 m_axis_tlast);
                        errors++;
                    end
                    if (m_axis_tuser !== want.ovf)
                    begin
                        $display("%0t: tuser expected %b actual %b", $time, want.ovf,
                                 m_axis_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int        total;
        int        size;
        logic      zero_mass;
        particle_t it;
        accepted = 0;
        errors   = 0;
        cycles   = 0;
        clear_set();
        rst_n = 1'b0;

        // single particle at the field extremes
        pending_q.push_back(mk_particle(32'h7fffffff, 32'h80000000, 32'h0, 31'h7fffffff,
                                        32'h80000000, 32'h7fffffff, 32'h0, 1'b1));
        // zero total mass, momentum sums that overflow a word
        pending_q.push_back(mk_particle(32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h0,
                                        32'h7fffffff, 32'h80000000, 32'h12345678, 1'b0));
        pending_q.push_back(mk_particle(32'h7fffffff, 32'h80000000, 32'h80000000, 31'h0,
                                        32'h80000000, 32'h7fffffff, 32'h0, 1'b0));
        pending_q.push_back(mk_particle(32'h7fffffff, 32'h80000000, 32'h1, 31'h0,
                                        32'h0, 32'hffffffff, 32'h1, 1'b1));
        // balanced extreme momenta with top mass: energy near the top of its range
        for (int i = 0; i < 4; i++)
        begin
            pending_q.push_back(mk_particle(i[0] ? 32'h7fffffff : 32'h80000000,
                                            i[0] ? 32'h80000000 : 32'h7fffffff,
                                            i[1] ? 32'h7fffffff : 32'h80000000,
                                            31'h7fffffff, 32'h7fffffff, 32'h80000000,
                                            i[0] ? 32'h7fffffff : 32'h80000000, i == 3));
        end
        // hold off the sender until every corrected beat has drained
        it = mk_particle(pick32(), pick32(), pick32(), pick_mass(), pick32(), pick32(),
                         pick32(), 1'b0);
        it.hold = 1'b1;
        pending_q.push_back(it);
        pending_q.push_back(mk_particle(pick32(), pick32(), pick32(), pick_mass(), pick32(),
                                        pick32(), pick32(), 1'b1));

        // random sets, mostly small; a few run past the store to exercise the drop flag
        total = pending_q.size();
        while (total < ITEM_GOAL)
        begin
            size = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 8);
            if (size > ITEM_GOAL - total)
            begin
                size = ITEM_GOAL - total;
            end
            zero_mass = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < size; i++)
            begin
                it = mk_particle(pick32(), pick32(), pick32(), zero_mass ? 31'h0 : pick_mass(),
                                 pick32(), pick32(), pick32(), i == size - 1);
                it.hold = (i == 0) && ($urandom_range(0, 29) == 0);
                pending_q.push_back(it);
            end
            total += size;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(posedge clk);
        end
        while (pending_q.size() > 0 || s_axis_tvalid || corrected_q.size() > 0);
        repeat (1000) @(posedge clk);

        if (errors == 0 && corrected_q.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/com_pkg.sv
design/com_ctrl.sv
design/com_dp.sv
design/center_of_mass_correction.sv
tb/center_of_mass_correction_test.sv
